/* sv/json_string_unescape_assert.svh */
// assertion macros for the json string unescape block
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/jsu_pkg.sv */
// shared types, codes and the utf-8 encoder of the json string unescape block
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int MaxResults = 6;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE      = 3'd0;
    localparam logic [2:0] ERR_UNTERM_STRING = 3'd1;
    localparam logic [2:0] ERR_UNTERM_ESCAPE = 3'd2;
    localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd3;
    localparam logic [2:0] ERR_TRUNC_UNICODE = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX       = 3'd5;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
    } res_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } utf8_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.len  = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.len  = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.len  = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end else begin
            r.len  = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

/* sv/json_string_unescape.sv */
// json string unescape block: decodes a quoted json string into utf-8 bytes
//
//  channel | direction | ports
//  --------+-----------+------------------------------------------------------
//  s_      | in        | s_valid s_ready s_command s_in_byte
//  m_      | out       | m_valid m_ready m_out_byte m_result_kind m_error_code
//          |           | m_last_of_run
//
// each transaction is decoded in the cycle it is taken; its 0..6 results go
// to a six-entry result register. while m_ready is high it drains one result
// per cycle, and the block takes one transaction per cycle when each has at
// most one result; more results hold the input until only the last is left.
// s_ready is high when the result register is empty or its last entry leaves.
// aresetn is synchronous, active low, and returns the decoder to idle.
`timescale 1ns / 1ps

module json_string_unescape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_result_kind,
    output logic [2:0] m_error_code,
    output logic       m_last_of_run
);

    `include "json_string_unescape_assert.svh"

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX,
        PH_HI_BS,
        PH_HI_U,
        PH_LOW
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [15:0]     hex_acc_reg, hex_acc_next;
    logic [2:0]      hex_seen_reg, hex_seen_next;
    logic            bad_reg, bad_next;
    logic [9:0]      pend_reg, pend_next;
    logic [2:0]      cnt_reg, cnt_next;
    jsu_pkg::res_t   res_reg [jsu_pkg::MaxResults];
    jsu_pkg::res_t   res_next [jsu_pkg::MaxResults];

    logic            s_accept;
    logic            m_accept;

    // decode of the current transaction
    logic            in_end;
    logic [7:0]      b;
    logic [3:0]      digit;
    logic            not_digit;
    logic [15:0]     acc_g;
    logic [2:0]      seen_g;
    logic            bad_g;
    logic            hi_en;
    logic            body_en;
    logic [20:0]     body_cp;
    logic            tail_en;
    jsu_pkg::res_t   tail;
    logic            do_str;
    logic            do_esc;
    logic            do_fail;
    logic [2:0]      fail_code;
    logic            do_judge;
    logic [15:0]     judge_cp;
    jsu_pkg::utf8_t  body_u;
    logic [2:0][7:0] hi_b;
    logic [2:0]      hi_n;
    logic [2:0]      body_n;
    logic [2:0]      load_cnt;
    jsu_pkg::res_t   load_res [jsu_pkg::MaxResults];

    // checker terms
    logic            hex_stale;
    logic            stray_data;

    assign in_end   = s_command;
    assign b        = s_in_byte;
    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;
    assign s_ready  = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_ready);

    assign m_valid       = (cnt_reg != 3'd0);
    assign m_out_byte    = res_reg[0].data;
    assign m_result_kind = res_reg[0].kind;
    assign m_error_code  = res_reg[0].code;
    assign m_last_of_run = (cnt_reg == 3'd1);

    always_comb begin
        digit     = 4'd0;
        not_digit = 1'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            digit = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            digit = 4'(b - 8'h61 + 8'd10);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            digit = 4'(b - 8'h41 + 8'd10);
        end else begin
            not_digit = 1'b1;
        end
    end

    assign acc_g  = {hex_acc_reg[11:0], digit};
    assign seen_g = hex_seen_reg + 3'd1;
    assign bad_g  = bad_reg | not_digit;

    always_comb begin
        phase_next    = phase_reg;
        hex_acc_next  = hex_acc_reg;
        hex_seen_next = hex_seen_reg;
        bad_next      = bad_reg;
        pend_next     = pend_reg;
        hi_en         = 1'b0;
        body_en       = 1'b0;
        body_cp       = '0;
        tail_en       = 1'b0;
        tail          = '0;
        do_str        = 1'b0;
        do_esc        = 1'b0;
        do_fail       = 1'b0;
        fail_code     = jsu_pkg::ERR_NO_QUOTE;
        do_judge      = 1'b0;
        judge_cp      = acc_g;

        unique case (phase_reg)
            PH_STR: begin
                if (in_end) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_UNTERM_STRING;
                end else begin
                    do_str = 1'b1;
                end
            end
            PH_ESC: begin
                if (in_end) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_UNTERM_ESCAPE;
                end else begin
                    do_esc = 1'b1;
                end
            end
            PH_HEX, PH_LOW: begin
                if (in_end) begin
                    hi_en     = (phase_reg == PH_LOW);
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_TRUNC_UNICODE;
                end else if (seen_g == 3'd4) begin
                    hex_acc_next  = '0;
                    hex_seen_next = '0;
                    bad_next      = 1'b0;
                    if (phase_reg == PH_HEX) begin
                        if (bad_g) begin
                            do_fail   = 1'b1;
                            fail_code = jsu_pkg::ERR_BAD_HEX;
                        end else begin
                            do_judge = 1'b1;
                        end
                    end else if (bad_g) begin
                        hi_en     = 1'b1;
                        do_fail   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_HEX;
                    end else if (acc_g[15:10] == 6'b110111) begin
                        body_en    = 1'b1;
                        body_cp    = jsu_pkg::SUPPLEMENTARY_BASE + {1'b0, pend_reg, acc_g[9:0]};
                        phase_next = PH_STR;
                    end else begin
                        hi_en    = 1'b1;
                        do_judge = 1'b1;
                    end
                end else begin
                    hex_acc_next  = acc_g;
                    hex_seen_next = seen_g;
                    bad_next      = bad_g;
                end
            end
            PH_HI_BS: begin
                if (in_end) begin
                    hi_en     = 1'b1;
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_UNTERM_STRING;
                end else if (b == jsu_pkg::CH_BACKSLASH) begin
                    phase_next = PH_HI_U;
                end else begin
                    hi_en  = 1'b1;
                    do_str = 1'b1;
                end
            end
            PH_HI_U: begin
                if (in_end) begin
                    hi_en     = 1'b1;
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_UNTERM_ESCAPE;
                end else if (b == jsu_pkg::CH_U) begin
                    hex_acc_next  = '0;
                    hex_seen_next = '0;
                    bad_next      = 1'b0;
                    phase_next    = PH_LOW;
                end else begin
                    hi_en  = 1'b1;
                    do_esc = 1'b1;
                end
            end
            default: begin
                if (!in_end && b == jsu_pkg::CH_QUOTE) begin
                    phase_next = PH_STR;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_NO_QUOTE;
                end
            end
        endcase

        // complete first code unit
        if (do_judge) begin
            if (judge_cp[15:10] == 6'b110110) begin
                pend_next  = judge_cp[9:0];
                phase_next = PH_HI_BS;
            end else begin
                body_en    = 1'b1;
                body_cp    = {5'd0, judge_cp};
                phase_next = PH_STR;
            end
        end

        if (do_str) begin
            if (b == jsu_pkg::CH_QUOTE) begin
                tail_en    = 1'b1;
                tail.kind  = jsu_pkg::KIND_CLOSE;
                phase_next = PH_IDLE;
            end else if (b == jsu_pkg::CH_BACKSLASH) begin
                phase_next = PH_ESC;
            end else begin
                tail_en    = 1'b1;
                tail.data  = b;
                tail.kind  = jsu_pkg::KIND_BYTE;
                phase_next = PH_STR;
            end
        end

        if (do_esc) begin
            tail.kind  = jsu_pkg::KIND_BYTE;
            phase_next = PH_STR;
            tail_en    = 1'b1;
            unique case (b)
                jsu_pkg::CH_QUOTE:     tail.data = jsu_pkg::CH_QUOTE;
                jsu_pkg::CH_BACKSLASH: tail.data = jsu_pkg::CH_BACKSLASH;
                jsu_pkg::CH_SLASH:     tail.data = jsu_pkg::CH_SLASH;
                jsu_pkg::CH_B:         tail.data = 8'h08;
                jsu_pkg::CH_F:         tail.data = 8'h0C;
                jsu_pkg::CH_N:         tail.data = 8'h0A;
                jsu_pkg::CH_R:         tail.data = 8'h0D;
                jsu_pkg::CH_T:         tail.data = 8'h09;
                jsu_pkg::CH_U: begin
                    tail_en       = 1'b0;
                    hex_acc_next  = '0;
                    hex_seen_next = '0;
                    bad_next      = 1'b0;
                    phase_next    = PH_HEX;
                end
                default: begin
                    tail_en   = 1'b0;
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_ESCAPE;
                end
            endcase
        end

        if (do_fail) begin
            tail_en       = 1'b1;
            tail          = '0;
            tail.kind     = jsu_pkg::KIND_ERR;
            tail.code     = fail_code;
            phase_next    = PH_IDLE;
            hex_acc_next  = '0;
            hex_seen_next = '0;
            bad_next      = 1'b0;
        end
    end

    // pending high surrogate as three utf-8 bytes
    assign hi_b[0] = 8'hED;
    assign hi_b[1] = {4'hA, pend_reg[9:6]};
    assign hi_b[2] = {2'b10, pend_reg[5:0]};

    assign body_u   = jsu_pkg::utf8_encode(body_cp);
    assign hi_n     = hi_en ? 3'd3 : 3'd0;
    assign body_n   = body_en ? body_u.len : 3'd0;
    assign load_cnt = hi_n + body_n + {2'b00, tail_en};

    always_comb begin
        logic [2:0] slot;
        logic [2:0] bk;
        slot = '0;
        bk   = '0;
        for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            slot        = 3'(i);
            bk          = slot - hi_n;
            load_res[i] = tail;
            if (slot < hi_n) begin
                load_res[i]      = '0;
                load_res[i].data = hi_b[slot[1:0]];
                load_res[i].kind = jsu_pkg::KIND_BYTE;
            end else if (bk < body_n) begin
                load_res[i]      = '0;
                load_res[i].data = body_u.b[bk[1:0]];
                load_res[i].kind = jsu_pkg::KIND_BYTE;
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            res_next[i] = res_reg[i];
        end
        if (s_accept) begin
            cnt_next = load_cnt;
            for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
                res_next[i] = load_res[i];
            end
        end else if (m_accept) begin
            cnt_next = cnt_reg - 3'd1;
            for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
                res_next[i] = res_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            res_reg[i] <= res_next[i];
        end
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            hex_acc_reg  <= '0;
            hex_seen_reg <= '0;
            bad_reg      <= 1'b0;
            pend_reg     <= '0;
            cnt_reg      <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_accept) begin
                phase_reg    <= phase_next;
                hex_acc_reg  <= hex_acc_next;
                hex_seen_reg <= hex_seen_next;
                bad_reg      <= bad_next;
                pend_reg     <= pend_next;
            end
        end
    end

    assign hex_stale  = (phase_reg == PH_IDLE || phase_reg == PH_STR)
                        && (hex_seen_reg != 3'd0 || bad_reg);
    assign stray_data = (m_result_kind != jsu_pkg::KIND_BYTE) && (m_out_byte != 8'd0);

    `JSU_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 3'd6, "count out of range")
    `JSU_ASSERT_NEXT(a_load_cnt, aclk, aresetn, s_accept, cnt_reg == $past(load_cnt), "bad load")
    `JSU_ASSERT_IMP(a_idle_hex, aclk, aresetn, 1'b1, !hex_stale, "stale hex state")
    `JSU_ASSERT_IMP(a_nonbyte_zero, aclk, aresetn, m_valid, !stray_data, "stray data")

endmodule
